// ----- rtl/depth_table_interpolator_core_defines.svh -----
// assertion helpers used by the core rtl file
`ifndef DEPTH_TABLE_INTERPOLATOR_CORE_DEFINES_SVH
`define DEPTH_TABLE_INTERPOLATOR_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DTI_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("dti check failed: same cycle");

// next-cycle implication, checked out of reset
`define DTI_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("dti check failed: next cycle");

`endif

// ----- rtl/dti_pkg.sv -----
`default_nettype none
package dti_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);

  localparam int DEPTH_W  = 31;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int KIND_W   = 3;
  localparam int DV_W     = VALUE_W + 1;
  localparam int QUOT_W   = DV_W;
  localparam int PROD_W   = DEPTH_W + QUOT_W;
  localparam int STEP_W   = $clog2(QUOT_W + 1);

  localparam logic [VALUE_W-1:0] EMPTY_DEFAULT_RESET = VALUE_W'(30000);

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam logic CFG_POINTS_IN_USE = 1'b0;
  localparam logic CFG_EMPTY_DEFAULT = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BELOW    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ABOVE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INTERP   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NO_SEG   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SCAN,
    ST_CALC
  } state_t;

  typedef struct packed {
    logic               go;
    logic [DEPTH_W-1:0] offset;
    logic [DV_W-1:0]    dv_mag;
    logic [DEPTH_W-1:0] span;
  } muldiv_req_t;

endpackage
`default_nettype wire

// ----- rtl/dti_table.sv -----
`default_nettype none
module dti_table (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [dti_pkg::IDX_W-1:0]     wr_addr,
  input  wire logic [dti_pkg::DEPTH_W-1:0]   wr_depth,
  input  wire logic [dti_pkg::VALUE_W-1:0]   wr_value,
  input  wire logic [dti_pkg::IDX_W-1:0]     rd_addr,
  output logic      [dti_pkg::DEPTH_W-1:0]   rd_depth,
  output logic      [dti_pkg::VALUE_W-1:0]   rd_value
);

  logic [dti_pkg::DEPTH_W-1:0] depth_mem [dti_pkg::MAX_POINTS];
  logic [dti_pkg::VALUE_W-1:0] value_mem [dti_pkg::MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      depth_mem[wr_addr] <= wr_depth;
      value_mem[wr_addr] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    rd_depth <= depth_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- rtl/dti_muldiv.sv -----
`default_nettype none
module dti_muldiv (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire dti_pkg::muldiv_req_t        req,
  output logic                             done,
  output logic [dti_pkg::VALUE_W-1:0]      quot
);

  logic                           running;
  logic                           mul_phase;
  logic [dti_pkg::STEP_W-1:0]     cnt;
  logic [dti_pkg::DEPTH_W-1:0]    op_a;
  logic [dti_pkg::DV_W-1:0]       op_b;
  logic [dti_pkg::DEPTH_W-1:0]    divisor;
  logic [dti_pkg::DEPTH_W-1:0]    rem;
  logic [dti_pkg::QUOT_W-1:0]     low;
  logic [dti_pkg::PROD_W-1:0]     prod;
  logic [dti_pkg::DEPTH_W:0]      partial;
  logic [dti_pkg::DEPTH_W:0]      diff;
  logic                           fits;

  assign prod    = dti_pkg::PROD_W'(op_a) * dti_pkg::PROD_W'(op_b);
  assign partial = {rem, low[dti_pkg::QUOT_W-1]};
  assign fits    = partial >= {1'b0, divisor};
  assign diff    = partial - {1'b0, divisor};
  assign quot    = low[dti_pkg::VALUE_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      mul_phase <= 1'b0;
      done      <= 1'b0;
      cnt       <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        running   <= 1'b1;
        mul_phase <= 1'b1;
      end else if (running && mul_phase) begin
        mul_phase <= 1'b0;
        cnt       <= dti_pkg::STEP_W'(dti_pkg::QUOT_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == dti_pkg::STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath: one product, then one restoring step per cycle
  always_ff @(posedge clk) begin
    if (req.go) begin
      op_a    <= req.offset;
      op_b    <= req.dv_mag;
      divisor <= req.span;
    end else if (running && mul_phase) begin
      // high part is already below the divisor since the quotient fits
      rem <= prod[dti_pkg::PROD_W-1:dti_pkg::QUOT_W];
      low <= prod[dti_pkg::QUOT_W-1:0];
    end else if (running) begin
      rem <= fits ? diff[dti_pkg::DEPTH_W-1:0] : partial[dti_pkg::DEPTH_W-1:0];
      low <= {low[dti_pkg::QUOT_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/depth_table_interpolator_core.sv -----
// piecewise linear lookup over a table of up to 64 (depth, value) breakpoints
// inputs: a word is taken when start is high and busy is low; command selects
//   a breakpoint write (point_index, point_depth, point_value) or a query
//   (query_depth); config is a plain write port (cfg_write, cfg_index,
//   cfg_data) for points_in_use and empty_default, used while idle
// outputs: one word per query on result_value / result_kind, flagged by
//   result_valid for exactly one cycle; the receiver cannot stall it
// timing: a write gives no word; a query on an empty table answers in the
//   cycle after start, a clamp below the first point is settled in state
//   FIRST and one above the last point in state LAST; a segment scan reads
//   one table entry per cycle, and interpolation then runs in the shared
//   unit: one multiply and 33 restoring divide steps
// busy stays high while a query runs and drops in the cycle the word is out,
//   so the next word can go in at that edge
// reset: points_in_use clears to 0, empty_default goes to 30000, the table
//   contents are undefined until written
`default_nettype none
`include "depth_table_interpolator_core_defines.svh"
module depth_table_interpolator_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                command,
  input  wire logic [dti_pkg::INDEX_W-1:0]         point_index,
  input  wire logic [dti_pkg::DEPTH_W-1:0]         point_depth,
  input  wire logic [dti_pkg::VALUE_W-1:0]         point_value,
  input  wire logic [dti_pkg::DEPTH_W-1:0]         query_depth,
  input  wire logic                                cfg_write,
  input  wire logic                                cfg_index,
  input  wire logic [dti_pkg::VALUE_W-1:0]         cfg_data,
  output logic                                     result_valid,
  output logic      [dti_pkg::VALUE_W-1:0]         result_value,
  output logic      [dti_pkg::KIND_W-1:0]          result_kind
);

  dti_pkg::state_t state, state_next;

  // config registers
  logic [dti_pkg::COUNT_W-1:0] points_in_use;
  logic [dti_pkg::VALUE_W-1:0] empty_default;

  // per-query working registers
  logic [dti_pkg::DEPTH_W-1:0] q_depth;
  logic [dti_pkg::IDX_W-1:0]   n_m1;     // last slot in use
  logic [dti_pkg::IDX_W-1:0]   k;        // slot whose entry is on the read port
  logic [dti_pkg::DEPTH_W-1:0] prev_depth;
  logic [dti_pkg::VALUE_W-1:0] prev_value;
  logic [dti_pkg::VALUE_W-1:0] last_value;
  logic                        dv_neg;

  // table port
  logic                        accept;
  logic                        tbl_wr;
  logic [dti_pkg::IDX_W-1:0]   rd_addr;
  logic [dti_pkg::DEPTH_W-1:0] rd_depth;
  logic [dti_pkg::VALUE_W-1:0] rd_value;

  // shared multiply/divide unit
  dti_pkg::muldiv_req_t        req;
  logic                        div_done;
  logic [dti_pkg::VALUE_W-1:0] div_quot;

  // decode
  logic                        n_zero;
  logic                        n_over;
  logic [dti_pkg::IDX_W-1:0]   n_m1_in;
  logic                        hit_first;
  logic                        hit_last;
  logic                        in_seg;
  logic                        zero_span;
  logic                        at_end;
  logic [dti_pkg::DV_W-1:0]    dv;
  logic [dti_pkg::VALUE_W-1:0] q_signed;
  logic [dti_pkg::VALUE_W-1:0] calc_value;

  // result staging
  logic                        emit;
  logic [dti_pkg::VALUE_W-1:0] emit_value;
  logic [dti_pkg::KIND_W-1:0]  emit_kind;

  assign busy   = state != dti_pkg::ST_IDLE;
  assign accept = start && !busy;
  assign tbl_wr = accept && command == dti_pkg::CMD_WRITE &&
                  32'(point_index) < dti_pkg::MAX_POINTS;

  // point count saturates at table size
  assign n_zero  = points_in_use == '0;
  assign n_over  = 32'(points_in_use) > dti_pkg::MAX_POINTS;
  assign n_m1_in = n_over ? dti_pkg::IDX_W'(dti_pkg::MAX_POINTS - 1)
                          : dti_pkg::IDX_W'(points_in_use - 1'b1);

  // compares against the entry on the read port
  assign hit_first = q_depth <= rd_depth;
  assign hit_last  = q_depth >= rd_depth;
  assign in_seg    = q_depth >= prev_depth && q_depth <= rd_depth;
  assign zero_span = rd_depth == prev_depth;
  assign at_end    = k == n_m1;

  // segment operands; the offset is never negative inside a segment
  assign dv = {rd_value[dti_pkg::VALUE_W-1], rd_value} -
              {prev_value[dti_pkg::VALUE_W-1], prev_value};

  always_comb begin
    req.go     = 1'b0;
    req.offset = q_depth - prev_depth;
    req.dv_mag = dv[dti_pkg::DV_W-1] ? -dv : dv;
    req.span   = rd_depth - prev_depth;
    if (state == dti_pkg::ST_SCAN && in_seg && !zero_span) begin
      req.go = 1'b1;
    end
  end

  // quotient is truncated toward zero, so the sign goes on the magnitude
  assign q_signed   = dv_neg ? -div_quot : div_quot;
  assign calc_value = prev_value + q_signed;

  dti_table u_table (
    .clk      (clk),
    .wr_en    (tbl_wr),
    .wr_addr  (dti_pkg::IDX_W'(point_index)),
    .wr_depth (point_depth),
    .wr_value (point_value),
    .rd_addr  (rd_addr),
    .rd_depth (rd_depth),
    .rd_value (rd_value)
  );

  dti_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .done (div_done),
    .quot (div_quot)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dti_pkg::ST_IDLE: begin
        if (accept && command == dti_pkg::CMD_QUERY && !n_zero) begin
          state_next = dti_pkg::ST_FIRST;
        end
      end
      dti_pkg::ST_FIRST: begin
        state_next = hit_first ? dti_pkg::ST_IDLE : dti_pkg::ST_LAST;
      end
      dti_pkg::ST_LAST: begin
        state_next = hit_last ? dti_pkg::ST_IDLE : dti_pkg::ST_SCAN;
      end
      dti_pkg::ST_SCAN: begin
        priority if (in_seg) begin
          state_next = zero_span ? dti_pkg::ST_IDLE : dti_pkg::ST_CALC;
        end else if (at_end) begin
          state_next = dti_pkg::ST_IDLE;
        end else begin
          state_next = dti_pkg::ST_SCAN;
        end
      end
      dti_pkg::ST_CALC: begin
        if (div_done) begin
          state_next = dti_pkg::ST_IDLE;
        end
      end
      default: state_next = dti_pkg::ST_IDLE;
    endcase
  end

  // outputs: read address and the result word to launch
  always_comb begin
    rd_addr    = '0;
    emit       = 1'b0;
    emit_value = empty_default;
    emit_kind  = dti_pkg::KIND_EMPTY;
    unique case (state)
      dti_pkg::ST_IDLE: begin
        // slot 0 is read speculatively for the next query
        if (accept && command == dti_pkg::CMD_QUERY && n_zero) begin
          emit = 1'b1;
        end
      end
      dti_pkg::ST_FIRST: begin
        rd_addr = n_m1;
        if (hit_first) begin
          emit       = 1'b1;
          emit_value = rd_value;
          emit_kind  = dti_pkg::KIND_BELOW;
        end
      end
      dti_pkg::ST_LAST: begin
        rd_addr = dti_pkg::IDX_W'(1);
        if (hit_last) begin
          emit       = 1'b1;
          emit_value = rd_value;
          emit_kind  = dti_pkg::KIND_ABOVE;
        end
      end
      dti_pkg::ST_SCAN: begin
        rd_addr = k + 1'b1;
        priority if (in_seg) begin
          // zero-width segment holds the left value
          if (zero_span) begin
            emit       = 1'b1;
            emit_value = prev_value;
            emit_kind  = dti_pkg::KIND_INTERP;
          end
        end else if (at_end) begin
          // non-monotonic table: nothing brackets the depth
          emit       = 1'b1;
          emit_value = last_value;
          emit_kind  = dti_pkg::KIND_NO_SEG;
        end else begin
          // keep scanning, no word yet
          emit = 1'b0;
        end
      end
      dti_pkg::ST_CALC: begin
        if (div_done) begin
          emit       = 1'b1;
          emit_value = calc_value;
          emit_kind  = dti_pkg::KIND_INTERP;
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dti_pkg::ST_IDLE;
      points_in_use <= '0;
      empty_default <= dti_pkg::EMPTY_DEFAULT_RESET;
      result_valid  <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
      if (cfg_write) begin
        unique case (cfg_index)
          dti_pkg::CFG_POINTS_IN_USE: points_in_use <= cfg_data[dti_pkg::COUNT_W-1:0];
          dti_pkg::CFG_EMPTY_DEFAULT: empty_default <= cfg_data;
          default:                    empty_default <= empty_default;
        endcase
      end
    end
  end

  // working registers and the result word
  always_ff @(posedge clk) begin
    if (emit) begin
      result_value <= emit_value;
      result_kind  <= emit_kind;
    end
    if (accept) begin
      q_depth <= query_depth;
      n_m1    <= n_m1_in;
    end
    unique case (state)
      dti_pkg::ST_FIRST: begin
        prev_depth <= rd_depth;
        prev_value <= rd_value;
      end
      dti_pkg::ST_LAST: begin
        last_value <= rd_value;
        k          <= dti_pkg::IDX_W'(1);
      end
      dti_pkg::ST_SCAN: begin
        if (in_seg) begin
          dv_neg <= dv[dti_pkg::DV_W-1];
        end else begin
          prev_depth <= rd_depth;
          prev_value <= rd_value;
          k          <= k + 1'b1;
        end
      end
      default: begin
        dv_neg <= dv_neg;
      end
    endcase
  end

  // checks
  `DTI_ASSERT_NOW(a_div_only_in_calc, clk, rst, div_done, state == dti_pkg::ST_CALC)
  `DTI_ASSERT_NOW(a_scan_in_range, clk, rst, state == dti_pkg::ST_SCAN, k <= n_m1)
  `DTI_ASSERT_NOW(a_late_word_after_busy, clk, rst, result_valid && result_kind != dti_pkg::KIND_EMPTY, $past(busy))
  `DTI_ASSERT_NEXT(a_query_goes_busy, clk, rst, accept && command == dti_pkg::CMD_QUERY && !n_zero, busy)

endmodule
`default_nettype wire
